/* hdl/png_su_pkg.sv */
// Shared types and constants for the PNG scanline unfilter core.
package png_su_pkg;

    // Filter type codes of a scanline.
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    // Configuration register indexes.
    localparam logic CFG_BPP        = 1'b0;
    localparam logic CFG_LINE_BYTES = 1'b1;

    localparam int          CFG_DATA_W    = 15;
    localparam logic [7:0]  FILT_TYPE_MAX = 8'd4;
    localparam logic [2:0]  BPP_MIN       = 3'd1;
    localparam logic [2:0]  BPP_MAX       = 3'd4;
    localparam logic [2:0]  BPP_RESET     = 3'd3;
    localparam logic [14:0] LINE_RESET    = 15'd3072;

    // One byte in the reconstruction stage.
    typedef struct packed {
        logic [7:0] byte_val;   // filtered byte or filter type
        logic       is_filt;    // filter-type beat
        logic       has_result; // gives an output beat
        logic       first_row;  // row above reads as zero
        logic       ge_bpp;     // left neighbour exists
        logic       last;       // last data byte of the line
        logic       bad;        // line filter type invalid
        filt_t      filt;       // line filter type
    } s1_item_t;

endpackage

/* hdl/png_scanline_unfilter_core.sv */
// PNG scanline unfilter core: filter-type decode, line buffer and byte reconstruction.
//
// Takes a decompressed PNG stream one byte per clock and returns reconstructed
// bytes (None/Sub/Up/Average/Paeth). Each accepted input beat is registered
// into the reconstruction stage, and its result is loaded into the output
// register when that stage moves on; the sustained rate is one byte per clock
// as long as out_ready stays high. The front end tracks line
// position, filter type and first-row status and issues the line-buffer read
// at acceptance; the reconstruction stage sees the byte above from the
// registered read port in the next cycle, computes the predictor and writes the
// reconstructed byte back at the same address. Filter-type beats give no
// output, except an invalid type (above 4), which gives one beat with
// bad_filter set and pixel_byte zero; the bytes of that line then pass through
// unchanged, flagged. Data bytes beyond line_bytes are dropped. The line
// buffer has no reset: the row above is defined once the first row of an
// image has been written. Configuration is written through a separate port
// that is always ready; write it only while the core is idle.
module png_scanline_unfilter_core #(
    parameter int MAX_LINE_BYTES = 16384
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input byte stream
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        byte_value,
    input  logic                              is_filter_type,
    input  logic                              image_start,
    // reconstructed bytes
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        pixel_byte,
    output logic                              end_of_line,
    output logic                              bad_filter,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [png_su_pkg::CFG_DATA_W-1:0] cfg_data
);
    import png_su_pkg::*;

    localparam int AW = $clog2(MAX_LINE_BYTES);       // line buffer address
    localparam int PW = $clog2(MAX_LINE_BYTES + 1);   // position, holds the max
    localparam int CW = (PW > CFG_DATA_W) ? PW : CFG_DATA_W;
    localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LINE_BYTES);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0]            bpp_reg;
    logic [CFG_DATA_W-1:0] line_bytes_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg        <= BPP_RESET;
            line_bytes_reg <= LINE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BPP:        bpp_reg        <= cfg_data[2:0];
                CFG_LINE_BYTES: line_bytes_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Clamp odd register values: bpp to 1..4, line length to 1..MAX.
    logic [2:0]    bpp_eff;
    logic [1:0]    bpp_idx;
    logic [CW-1:0] lb_ext;
    logic [CW-1:0] len_eff;

    always_comb
    begin
        if (bpp_reg < BPP_MIN)
            bpp_eff = BPP_MIN;
        else if (bpp_reg > BPP_MAX)
            bpp_eff = BPP_MAX;
        else
            bpp_eff = bpp_reg;
        bpp_idx = 2'(bpp_eff - 3'd1);

        lb_ext = CW'(line_bytes_reg);
        if (lb_ext == '0)
            len_eff = CW'(1);
        else if (lb_ext > LEN_MAX)
            len_eff = LEN_MAX;
        else
            len_eff = lb_ext;
    end

    // ------------------------------------------------------------------
    // Front end: line position, filter type, first-row flag
    // ------------------------------------------------------------------
    logic [PW-1:0] pos_reg, pos_next;
    logic          first_row_reg, first_row_next;
    filt_t         filt_reg, filt_next;
    logic          bad_reg, bad_next;

    logic          in_fire;
    logic          pos_ok;
    logic [PW-1:0] pos_inc;
    logic          at_last;
    logic          filt_invalid;
    s1_item_t      item_new;

    assign in_fire      = in_valid && in_ready;
    assign pos_ok       = CW'(pos_reg) < len_eff;
    assign pos_inc      = pos_reg + PW'(1);
    assign at_last      = CW'(pos_inc) >= len_eff;
    assign filt_invalid = byte_value > FILT_TYPE_MAX;

    always_comb
    begin
        pos_next       = pos_reg;
        first_row_next = first_row_reg;
        filt_next      = filt_reg;
        bad_next       = bad_reg;

        if (in_fire)
        begin
            if (is_filter_type)
            begin
                pos_next = '0;
                if (image_start)
                    first_row_next = 1'b1;
                if (filt_invalid)
                begin
                    filt_next = FILT_NONE;
                    bad_next  = 1'b1;
                end
                else
                begin
                    filt_next = filt_t'(byte_value[2:0]);
                    bad_next  = 1'b0;
                end
            end
            else if (pos_ok)
            begin
                pos_next = pos_inc;
                if (at_last)
                    first_row_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        item_new.byte_val   = byte_value;
        item_new.is_filt    = is_filter_type;
        item_new.has_result = is_filter_type ? filt_invalid : pos_ok;
        item_new.first_row  = first_row_reg;
        item_new.ge_bpp     = pos_reg >= PW'(bpp_eff);
        item_new.last       = at_last;
        item_new.bad        = bad_reg;
        item_new.filt       = filt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            first_row_reg <= 1'b1;
            filt_reg      <= FILT_NONE;
            bad_reg       <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            first_row_reg <= first_row_next;
            filt_reg      <= filt_next;
            bad_reg       <= bad_next;
        end
    end

    // ------------------------------------------------------------------
    // Line buffer: read at acceptance, written back from the recon stage.
    // A byte and the next read of its address are always separated by a
    // filter beat, so a read never meets a write to the same entry.
    // ------------------------------------------------------------------
    logic [7:0]    line_mem [MAX_LINE_BYTES];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] raddr;
    logic          mem_re;
    logic          mem_we;
    logic [AW-1:0] waddr_reg;
    logic [7:0]    recon;

    assign raddr  = pos_reg[AW-1:0];
    assign mem_re = in_fire && !is_filter_type && pos_ok;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[waddr_reg] <= recon;
        if (mem_re)
            rdata_reg <= line_mem[raddr];
    end

    // ------------------------------------------------------------------
    // Reconstruction stage
    // ------------------------------------------------------------------
    s1_item_t s1_reg;
    logic     s1_valid_reg;
    logic     s1_go;
    logic     out_free;

    logic [7:0] left_reg   [4];
    logic [7:0] upleft_reg [4];

    assign out_free = !out_valid || out_ready;
    assign s1_go    = s1_valid_reg && (out_free || !s1_reg.has_result);
    assign in_ready = !s1_valid_reg || s1_go;
    assign mem_we   = s1_go && !s1_reg.is_filt && s1_reg.has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_fire;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg    <= item_new;
            waddr_reg <= raddr;
        end
    end

    // neighbours
    logic [7:0] nb_a, nb_b, nb_c;
    logic [7:0] pred;
    logic [8:0] avg_sum;
    logic [7:0] pa, pb;
    logic [9:0] ab_sum, c_dbl, pc;
    logic [7:0] paeth_val;

    always_comb
    begin
        nb_a = s1_reg.ge_bpp ? left_reg[bpp_idx] : 8'd0;
        nb_b = s1_reg.first_row ? 8'd0 : rdata_reg;
        nb_c = (s1_reg.ge_bpp && !s1_reg.first_row) ? upleft_reg[bpp_idx] : 8'd0;

        // Paeth distances without signed math
        pa     = (nb_b >= nb_c) ? nb_b - nb_c : nb_c - nb_b;
        pb     = (nb_a >= nb_c) ? nb_a - nb_c : nb_c - nb_a;
        ab_sum = {2'b00, nb_a} + {2'b00, nb_b};
        c_dbl  = {1'b0, nb_c, 1'b0};
        pc     = (ab_sum >= c_dbl) ? ab_sum - c_dbl : c_dbl - ab_sum;
        if ({2'b00, pa} <= {2'b00, pb} && {2'b00, pa} <= pc)
            paeth_val = nb_a;
        else if ({2'b00, pb} <= pc)
            paeth_val = nb_b;
        else
            paeth_val = nb_c;

        avg_sum = {1'b0, nb_a} + {1'b0, nb_b};

        if (s1_reg.bad)
            pred = 8'd0;
        else
        begin
            case (s1_reg.filt)
                FILT_SUB:   pred = nb_a;
                FILT_UP:    pred = nb_b;
                FILT_AVG:   pred = avg_sum[8:1];
                FILT_PAETH: pred = paeth_val;
                default:    pred = 8'd0;
            endcase
        end

        recon = s1_reg.byte_val + pred;
    end

    // left / above-left history, newest first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                left_reg[k]   <= 8'd0;
                upleft_reg[k] <= 8'd0;
            end
        end
        else if (s1_go)
        begin
            if (s1_reg.is_filt)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    left_reg[k]   <= 8'd0;
                    upleft_reg[k] <= 8'd0;
                end
            end
            else if (s1_reg.has_result)
            begin
                for (int k = 3; k > 0; k--)
                begin
                    left_reg[k]   <= left_reg[k-1];
                    upleft_reg[k] <= upleft_reg[k-1];
                end
                left_reg[0]   <= recon;
                upleft_reg[0] <= nb_b;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic out_load;

    assign out_load = s1_go && s1_reg.has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (out_free)
            out_valid <= out_load;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (s1_reg.is_filt)
            begin
                pixel_byte  <= 8'd0;
                end_of_line <= 1'b0;
                bad_filter  <= 1'b1;
            end
            else
            begin
                pixel_byte  <= recon;
                end_of_line <= s1_reg.last;
                bad_filter  <= s1_reg.bad;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An empty recon stage always takes input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("in_ready low with empty recon stage");

    // A stalled recon stage keeps its byte above.
    a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> $stable(rdata_reg))
        else $error("line buffer read data lost during stall");

    // Read and write-back never hit the same entry in one cycle.
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_re && mem_we) |-> (raddr != waddr_reg))
        else $error("line buffer read/write collision");

endmodule
